>>> src/mmcs_pkg.sv
// Shared types and constants for the min-max contrast stretch unit.
package mmcs_pkg;

	// Sample width; the binary point cancels in the ratio, so only the width matters.
	localparam int SAMPLE_WIDTH = 32;
	// The scaled dividend is diff * 255, which needs eight more bits than diff.
	localparam int REM_W = SAMPLE_WIDTH + 8;
	// The divisor starts at span shifted up by seven places.
	localparam int DVS_W = SAMPLE_WIDTH + 7;
	localparam int QUOT_W = 8;
	localparam int STEP_W = $clog2(QUOT_W);

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_SCALE   = 1'b1;

	localparam logic [QUOT_W-1:0] BYTE_MAX = '1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic measure_en;   // fold the input sample into min/max
		logic scale_load;   // capture the input sample of a scale item
		logic prep;         // form difference, span and special-case flags
		logic load;         // form the dividend and the shifted divisor
		logic div_step;     // one restoring division step
		logic result_load;  // move the finished byte into the output register
	} mmcs_cmd_t;

endpackage

>>> src/mmcs_datapath.sv
// Datapath: running min/max, divider and output register of the stretch unit.
module mmcs_datapath import mmcs_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mmcs_cmd_t                      cmd,
	input  logic                           first_of_pass,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic        [QUOT_W-1:0]       pixel_byte,
	output logic                           degenerate
);

	logic signed [SAMPLE_WIDTH-1:0] min_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;

	logic [SAMPLE_WIDTH-1:0] diff_q;
	logic [SAMPLE_WIDTH-1:0] span_q;
	logic                    degen_q;
	logic                    below_q;
	logic                    sat_q;

	logic [REM_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [QUOT_W-1:0] quot_q;

	logic [SAMPLE_WIDTH:0] diff_full;
	logic [SAMPLE_WIDTH:0] span_full;
	logic [REM_W-1:0]      dividend;
	logic [REM_W-1:0]      dvs_ext;
	logic                  take;

	// Differences are exact in one extra bit; only the low bits are kept,
	// since they are used solely where they are known to be positive.
	assign diff_full = {sample_q[SAMPLE_WIDTH-1], sample_q} - {min_q[SAMPLE_WIDTH-1], min_q};
	assign span_full = {max_q[SAMPLE_WIDTH-1], max_q} - {min_q[SAMPLE_WIDTH-1], min_q};

	// diff * 255 as (diff << 8) - diff.
	assign dividend = {diff_q, 8'd0} - {8'd0, diff_q};

	assign dvs_ext = {1'b0, dvs_q};
	assign take    = rem_q >= dvs_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			max_q <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else if (cmd.measure_en) begin
			if (first_of_pass) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				if (sample < min_q) min_q <= sample;
				if (sample > max_q) max_q <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale_load) sample_q <= sample;
		if (cmd.prep) begin
			diff_q  <= diff_full[SAMPLE_WIDTH-1:0];
			span_q  <= span_full[SAMPLE_WIDTH-1:0];
			degen_q <= max_q <= min_q;
			below_q <= sample_q <= min_q;
		end
		if (cmd.load) begin
			rem_q  <= dividend;
			dvs_q  <= {span_q, 7'd0};
			quot_q <= '0;
			// The quotient reaches 255 exactly when diff is at least the span.
			sat_q  <= diff_q >= span_q;
		end
		if (cmd.div_step) begin
			if (take) rem_q <= rem_q - dvs_ext;
			dvs_q  <= dvs_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], take};
		end
		if (cmd.result_load) begin
			degenerate <= degen_q;
			if (degen_q || below_q) pixel_byte <= '0;
			else if (sat_q)         pixel_byte <= BYTE_MAX;
			else                    pixel_byte <= quot_q;
		end
	end

endmodule

>>> src/mmcs_ctrl.sv
// Controller: handshakes and division sequencing of the stretch unit.
module mmcs_ctrl import mmcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      command,
	output logic      out_valid,
	input  logic      out_ready,
	output mmcs_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              in_fire;
	logic              out_free;

	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (command == CMD_SCALE) begin
						cmd.scale_load = 1'b1;
						state_d        = S_PREP;
					end else begin
						cmd.measure_en = 1'b1;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(QUOT_W - 1)) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)          step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + 1'b1;
			if (cmd.result_load)   out_valid_q <= 1'b1;
			else if (out_ready)    out_valid_q <= 1'b0;
		end
	end

endmodule

>>> src/minmax_contrast_stretch_unit.sv
// Top level of the min-max contrast stretch unit: controller, datapath and checks.
//
// The unit maps signed Q16.16 samples to bytes in two passes. The input channel
// (in_valid/in_ready) carries items of command, first_of_pass and sample. A measure
// item folds its sample into the running minimum and maximum; with first_of_pass
// set it restarts tracking from that sample. A measure item gives no result and
// leaves the input open, so measure items can stream at one per clock while idle.
// A scale item gives one result on the output channel (out_valid/out_ready):
// pixel_byte = floor((sample - min) * 255 / (max - min)) clamped to 0..255, and
// degenerate = 1 with pixel_byte = 0 when max <= min (including nothing measured).
// A scale item is worked out by a restoring divider, one quotient bit per cycle:
// it forms the differences, then the dividend, runs eight divide steps and loads
// the output register, and only then opens the input for the next item, so a new
// item is not taken while a scale item is in work.
// The output register holds a finished item while the receiver stalls; measure
// items are still taken meanwhile, and a further scale item waits in its last
// step until the output register frees.
// Reset (arst_n low) empties the output register, returns the controller to idle
// and sets the minimum to the largest and the maximum to the smallest value.
module minmax_contrast_stretch_unit import mmcs_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic                           first_of_pass,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic        [QUOT_W-1:0]       pixel_byte,
	output logic                           degenerate
);

	mmcs_cmd_t cmd;

	// The controller owns both handshakes and sequences the divider.
	mmcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath keeps min/max, divides, and holds the output register.
	mmcs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.first_of_pass (first_of_pass),
		.sample        (sample),
		.pixel_byte    (pixel_byte),
		.degenerate    (degenerate)
	);

	// A degenerate result always carries a zero byte.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> pixel_byte == '0)
		else $error("degenerate result with nonzero byte");

	// Taking a scale item closes the input until its result is finished.
	a_scale_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_SCALE |=> !in_ready)
		else $error("input open while a scale item is in the divider");

	// A new result only comes from the final step, while the input is closed.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a scale item in flight");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the min-max contrast stretch unit.
module tb;
	import mmcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = ~MOST_NEG;

	// One expected result item: the stretched byte and the degenerate flag.
	typedef struct packed {
		logic [QUOT_W-1:0] pixel;
		logic              degen;
	} stretched_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           command;
	logic                           first_of_pass;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           out_valid;
	logic                           out_ready;
	logic        [QUOT_W-1:0]       pixel_byte;
	logic                           degenerate;

	minmax_contrast_stretch_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.first_of_pass(first_of_pass),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_byte   (pixel_byte),
		.degenerate   (degenerate)
	);

	// Our own copy of the running range, updated as each measure item is accepted.
	logic signed [SAMPLE_WIDTH-1:0] track_min;
	logic signed [SAMPLE_WIDTH-1:0] track_max;

	// Stretched bytes still owed by the unit, oldest first.
	stretched_t pending_bytes[$];

	int mismatches;
	int send_idle_pct;
	int recv_stall_pct;

	// The clock toggles every half period of 10 ns.
	always #10 clk = ~clk;

	// The receiver decides at each falling edge whether it will take a result at
	// the next rising edge.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Reports a failure. Only the first ten are described in full; later ones
	// are just counted so the log stays short.
	function automatic void flag_mismatch(string what, stretched_t want, stretched_t got);
		if (mismatches < 10) begin
			$display("MISMATCH %s: expected byte %0d degen %0b, got byte %0d degen %0b",
				what, want.pixel, want.degen, got.pixel, got.degen);
		end
		mismatches++;
	endfunction

	// Works out the stretched byte for a scale item from the range seen so far.
	// Everything is carried in 64 bits so (sample - min) * 255 cannot overflow.
	function automatic stretched_t stretch_sample(logic signed [SAMPLE_WIDTH-1:0] s);
		longint lo;
		longint hi;
		longint sv;
		longint unsigned span;
		longint unsigned diff;
		longint unsigned quot;
		stretched_t r;
		lo = track_min;
		hi = track_max;
		sv = s;
		r.pixel = '0;
		r.degen = 1'b0;
		if (hi <= lo) begin
			// Nothing measured or a flat image: there is no span to divide by.
			r.degen = 1'b1;
		end else if (sv > lo) begin
			span = hi - lo;
			diff = sv - lo;
			quot = (diff * 255) / span;
			r.pixel = (quot > BYTE_MAX) ? BYTE_MAX : quot[QUOT_W-1:0];
		end
		return r;
	endfunction

	// Folds an accepted item into the predicted state, or queues its result.
	function automatic void absorb_item(logic cmd, logic first, logic signed [SAMPLE_WIDTH-1:0] s);
		if (cmd == CMD_MEASURE) begin
			if (first) begin
				track_min = s;
				track_max = s;
			end else begin
				if (s < track_min) track_min = s;
				if (s > track_max) track_max = s;
			end
		end else begin
			pending_bytes.push_back(stretch_sample(s));
		end
	endfunction

	// Offers one item. Inputs change only at falling edges; the item counts as
	// taken at the rising edge where in_ready is seen high.
	task automatic send_item(logic cmd, logic first, logic signed [SAMPLE_WIDTH-1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		command       = cmd;
		first_of_pass = first;
		sample        = s;
		in_valid      = 1'b1;
		do @(posedge clk); while (!in_ready);
		absorb_item(cmd, first, s);
	endtask

	// Checks every result the unit hands over against the oldest expectation.
	always @(posedge clk) begin
		stretched_t got;
		stretched_t want;
		if (arst_n && out_valid && out_ready) begin
			got.pixel = pixel_byte;
			got.degen = degenerate;
			if (pending_bytes.size() == 0) begin
				flag_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_bytes.pop_front();
				if (got.pixel !== want.pixel || got.degen !== want.degen) begin
					flag_mismatch("scaled pixel", want, got);
				end
			end
		end
	end

	// Scale items straight after reset: min sits above max, so the result must be
	// flagged degenerate. The first flag on a scale item must change nothing.
	task automatic test_nothing_measured();
		send_item(CMD_SCALE, 1'b0, '0);
		send_item(CMD_SCALE, 1'b1, MOST_POS);
		send_item(CMD_SCALE, 1'b0, MOST_NEG);
	endtask

	// A flat image: every measured sample is the same, so max equals min.
	task automatic test_equal_samples();
		send_item(CMD_MEASURE, 1'b1, 32'sd5);
		send_item(CMD_MEASURE, 1'b0, 32'sd5);
		send_item(CMD_SCALE, 1'b0, 32'sd5);
		send_item(CMD_SCALE, 1'b0, -32'sd7);
	endtask

	// The widest possible span, from the most negative to the most positive value.
	task automatic test_full_range();
		send_item(CMD_MEASURE, 1'b1, MOST_NEG);
		send_item(CMD_MEASURE, 1'b0, MOST_POS);
		send_item(CMD_SCALE, 1'b0, MOST_NEG);
		send_item(CMD_SCALE, 1'b0, MOST_POS);
		send_item(CMD_SCALE, 1'b0, '0);
		send_item(CMD_SCALE, 1'b1, -32'sd1);
	endtask

	// Samples outside the measured range clamp to 0 below and 255 above. A later
	// first flag restarts the range even when the old one was wider.
	task automatic test_clamping();
		send_item(CMD_MEASURE, 1'b1, 32'sd100);
		send_item(CMD_MEASURE, 1'b0, 32'sd200);
		send_item(CMD_SCALE, 1'b0, 32'sd50);
		send_item(CMD_SCALE, 1'b0, 32'sd300);
		send_item(CMD_SCALE, 1'b0, 32'sd150);
		send_item(CMD_SCALE, 1'b0, 32'sd199);
		send_item(CMD_MEASURE, 1'b1, -32'sd1);
		send_item(CMD_MEASURE, 1'b0, 32'sd1);
		send_item(CMD_SCALE, 1'b1, 32'sd0);
	endtask

	// Random traffic. Most of it is whole passes: a measure item with the first
	// flag, a few more measures, then scale items over the same range. The range
	// is sometimes full width, sometimes narrow, and sometimes a single value so
	// that degenerate results keep turning up. The rest is loose random items.
	task automatic test_random(int n_items, int idle_pct, int stall_pct);
		int sent;
		int n_meas;
		int n_scale;
		int shape;
		logic signed [SAMPLE_WIDTH-1:0] base;
		logic [SAMPLE_WIDTH-1:0] spread;
		logic signed [SAMPLE_WIDTH-1:0] s;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) < 8) begin
				shape = $urandom_range(3);
				base  = $urandom;
				case (shape)
					0: spread = '1;
					1: spread = $urandom_range(15);
					2: spread = '0;
					default: spread = $urandom_range(32'h000f_ffff);
				endcase
				n_meas  = $urandom_range(1, 6);
				n_scale = $urandom_range(1, 6);
				for (int i = 0; i < n_meas; i++) begin
					s = base + $urandom_range(spread);
					send_item(CMD_MEASURE, (i == 0), s);
				end
				for (int i = 0; i < n_scale; i++) begin
					// Now and then a sample well off the range to hit the clamps.
					if ($urandom_range(3) == 0) s = $urandom;
					else s = base + $urandom_range(spread);
					send_item(CMD_SCALE, 1'($urandom_range(1)), s);
				end
				sent += n_meas + n_scale;
			end else begin
				send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
				sent++;
			end
		end
	endtask

	// Waits for the outstanding results, then waits on in case a stray result follows.
	task automatic drain_results();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (24) @(posedge clk);
		if (pending_bytes.size() != 0) begin
			if (mismatches < 10) begin
				$display("MISMATCH: %0d results never arrived", pending_bytes.size());
			end
			mismatches++;
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		command        = CMD_MEASURE;
		first_of_pass  = 1'b0;
		sample         = '0;
		out_ready      = 1'b0;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		track_min      = MOST_POS;
		track_max      = MOST_NEG;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_nothing_measured();
		test_equal_samples();
		test_full_range();
		test_clamping();
		// Idling phases: none, sender only, receiver only, then both.
		test_random(232, 0, 0);
		test_random(232, 62, 0);
		test_random(232, 0, 62);
		test_random(232, 32, 32);
		drain_results();

		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// Safety net in case a handshake never completes.
	initial begin
		#10ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule
